FILE: hw/rtl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Types, constants and the CRC-8 byte update shared by the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

  localparam int BYTE_W    = 8;
  localparam int IDX_W     = 3;
  localparam int CRC_W     = 8;
  localparam int RAW_W     = 20;
  localparam int OFF_W     = 16;
  localparam int VAL_W     = 19;
  localparam int CFG_IDX_W = 8;
  localparam int OUT_PAD_W = 2;

  localparam logic [CRC_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 8'h31;

  // byte positions within a reply
  localparam logic [IDX_W-1:0] POS_HUM_HI   = 3'd1;
  localparam logic [IDX_W-1:0] POS_HUM_MID  = 3'd2;
  localparam logic [IDX_W-1:0] POS_SPLIT    = 3'd3;
  localparam logic [IDX_W-1:0] POS_TEMP_MID = 3'd4;
  localparam logic [IDX_W-1:0] POS_TEMP_LO  = 3'd5;
  localparam logic [IDX_W-1:0] POS_CHECK    = 3'd6;

  localparam logic [6:0]       HUM_SCALE  = 7'd100;
  localparam logic [7:0]       TEMP_SCALE = 8'd200;
  localparam logic [VAL_W-1:0] TEMP_BIAS  = 19'd51200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUM_OFFSET  = 8'd0,
    REG_TEMP_OFFSET = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CRC_W-1:0] crc;
    logic [RAW_W-1:0] hum_raw;
    logic [RAW_W-1:0] temp_raw;
  } frame_state_t;

  // msb-first crc-8 over one byte
  function automatic logic [CRC_W-1:0] crc8_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/htfd_frame_acc.sv
// ----------------------------------------------------------------------------
// htfd_frame_acc
// Byte counter, running CRC and raw field capture for one sensor reply.
// ----------------------------------------------------------------------------
module htfd_frame_acc (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  logic [7:0]            frame_byte,
  input  logic                  frame_start,
  output htfd_pkg::frame_state_t frame_st,
  output logic                  is_last
);
  import htfd_pkg::*;

  frame_state_t     st_r;
  frame_state_t     st_nxt;
  logic [IDX_W-1:0] idx;
  logic [CRC_W-1:0] crc_base;

  always_comb begin
    idx      = frame_start ? '0 : st_r.idx;
    crc_base = frame_start ? CRC_INIT : st_r.crc;
    // anything past the last data byte counts as the checksum position
    is_last  = (idx >= POS_CHECK);
  end

  always_comb begin
    st_nxt = st_r;
    if (accept) begin
      if (is_last) begin
        st_nxt.idx = '0;
        st_nxt.crc = CRC_INIT;
      end else begin
        st_nxt.idx = idx + 3'd1;
        st_nxt.crc = crc8_byte(crc_base, frame_byte);
        case (idx)
          POS_HUM_HI:   st_nxt.hum_raw[19:12] = frame_byte;
          POS_HUM_MID:  st_nxt.hum_raw[11:4]  = frame_byte;
          POS_SPLIT: begin
            st_nxt.hum_raw[3:0]    = frame_byte[7:4];
            st_nxt.temp_raw[19:16] = frame_byte[3:0];
          end
          POS_TEMP_MID: st_nxt.temp_raw[15:8] = frame_byte;
          POS_TEMP_LO:  st_nxt.temp_raw[7:0]  = frame_byte;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.idx      <= '0;
      st_r.crc      <= CRC_INIT;
      st_r.hum_raw  <= '0;
      st_r.temp_raw <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign frame_st = st_r;

endmodule

FILE: hw/rtl/htfd_scale.sv
// ----------------------------------------------------------------------------
// htfd_scale
// Converts raw humidity and temperature to 1/1024 units and adds offsets.
// ----------------------------------------------------------------------------
module htfd_scale (
  input  logic        [19:0] hum_raw,
  input  logic        [19:0] temp_raw,
  input  logic signed [15:0] hum_offset,
  input  logic signed [15:0] temp_offset,
  output logic signed [18:0] humidity_value,
  output logic signed [18:0] temperature_value
);
  import htfd_pkg::*;

  logic [26:0]      hum_prod;
  logic [27:0]      temp_prod;
  logic [VAL_W-1:0] hum_off_ext;
  logic [VAL_W-1:0] temp_off_ext;
  logic [VAL_W-1:0] hum_sum;
  logic [VAL_W-1:0] temp_sum;

  always_comb begin
    hum_prod     = {7'd0, hum_raw} * {20'd0, HUM_SCALE};
    temp_prod    = {8'd0, temp_raw} * {20'd0, TEMP_SCALE};
    hum_off_ext  = {{(VAL_W-OFF_W){hum_offset[OFF_W-1]}}, hum_offset};
    temp_off_ext = {{(VAL_W-OFF_W){temp_offset[OFF_W-1]}}, temp_offset};
    // drop the ten fraction bits, then wrap to the result width
    hum_sum  = {2'b00, hum_prod[26:10]} + hum_off_ext;
    temp_sum = {1'b0, temp_prod[27:10]} - TEMP_BIAS + temp_off_ext;
  end

  assign humidity_value    = $signed(hum_sum);
  assign temperature_value = $signed(temp_sum);

endmodule

FILE: hw/rtl/humidity_temp_frame_decoder.sv
// A result item is presented in the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle while no checksum byte is waiting on a held result;
// the raw*scale multiply with offset add sits between frame state and output register.
// A checksum byte waits only while a previous result is still held; other bytes never do.
// Reset (rst_n low, synchronous): byte count 0, crc 0xFF, raw fields and offsets 0,
// no result pending.
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes seven-byte humidity/temperature replies with crc-8 check.
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [18:0] humidity_value, [37:19] temperature_value
  output logic        out_tuser,  // [0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [htfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import htfd_pkg::*;

  frame_state_t            frame_st;
  logic                    acc_last;
  logic                    in_fire;
  logic                    res_fire;
  logic signed [OFF_W-1:0] hum_off_r;
  logic signed [OFF_W-1:0] temp_off_r;
  logic signed [VAL_W-1:0] hum_val;
  logic signed [VAL_W-1:0] temp_val;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [VAL_W-1:0]        out_hum_r;
  logic [VAL_W-1:0]        out_temp_r;
  logic                    out_status_r;

  assign in_tready = !acc_last || !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign res_fire  = in_fire && acc_last;
  assign cfg_ready = 1'b1;

  htfd_frame_acc u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_fire),
    .frame_byte  (in_tdata),
    .frame_start (in_tuser),
    .frame_st    (frame_st),
    .is_last     (acc_last)
  );

  htfd_scale u_scale (
    .hum_raw           (frame_st.hum_raw),
    .temp_raw          (frame_st.temp_raw),
    .hum_offset        (hum_off_r),
    .temp_offset       (temp_off_r),
    .humidity_value    (hum_val),
    .temperature_value (temp_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hum_off_r  <= '0;
      temp_off_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HUM_OFFSET:  hum_off_r  <= $signed(cfg_data);
        REG_TEMP_OFFSET: temp_off_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      out_hum_r    <= hum_val;
      out_temp_r   <= temp_val;
      out_status_r <= (frame_st.crc != in_tdata);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_temp_r, out_hum_r};
  assign out_tuser  = out_status_r;

  // a checksum byte is never taken over a held result
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> (!out_valid_r || out_tready))
    else $error("result overwritten while held");

  // a result only appears after a checksum byte
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |=> (!out_valid_r || $past(res_fire)))
    else $error("result without checksum byte");

  // frame end restarts count and crc
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> (frame_st.idx == '0 && frame_st.crc == CRC_INIT))
    else $error("frame state not restarted");

  // byte count stays within a reply
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    frame_st.idx <= POS_CHECK)
    else $error("byte count out of range");

endmodule
